// File: src/mchw_pkg.sv
package mchw_pkg;

   localparam int CHANNELS    = 16;
   localparam int TIME_BITS   = 32;
   localparam int MAX_RESULTS = 16;
   localparam int IDX_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [1:0] {
      OP_REGISTER  = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_CHECK     = 2'd2
   } op_type;

   localparam logic ACT_RESTART  = 1'b0;
   localparam logic ACT_SYSRESET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [3:0] hit_slot;
      logic       action;
      logic       kill_first;
   } result_type;

endpackage

// File: src/mchw_req_if.sv
interface mchw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [3:0]  slot;
   logic [31:0] limit_ms;
   logic        can_restart;
   logic        holds_handle;
   logic [31:0] now_ms;

   modport source (output valid, output op, output slot, output limit_ms,
                   output can_restart, output holds_handle, output now_ms,
                   input ready);
   modport sink (input valid, input op, input slot, input limit_ms,
                 input can_restart, input holds_handle, input now_ms,
                 output ready);
endinterface

// File: src/mchw_rsp_if.sv
interface mchw_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] hit_slot;
   logic       action;
   logic       kill_first;
   logic       last_of_run;

   modport source (output valid, output hit_slot, output action, output kill_first,
                   output last_of_run, input ready);
   modport sink (input valid, input hit_slot, input action, input kill_first,
                 input last_of_run, output ready);
endinterface

// File: src/multi_channel_heartbeat_watchdog.sv
// Heartbeat watchdog over CHANNELS slots. Register and heartbeat requests write the slot
// tables when accepted. A check request scans the slots in index order through one read
// address shared by the time-stamp and limit memories and one shared subtract-and-compare
// unit, each slot passing through a read and an evaluate state; a flush state then hands
// over the final result. A system reset result ends the scan early; evaluation waits
// while a held result cannot move to the output. One timed-out slot is held back until
// the next is found, so that the final result of a check carries last_of_run. No new
// request is taken while a check is in progress; results drain through an output register.
module multi_channel_heartbeat_watchdog
   import mchw_pkg::*;
(
   input logic         clock,
   input logic         reset,
   mchw_req_if.sink    req,
   mchw_rsp_if.source  rsp
);

   state_type               state_ff, state_in;
   idx_type                 idx_ff, idx_in;
   cnt_type                 cnt_ff, cnt_in;
   time_type                now_ff, now_in;
   logic [CHANNELS-1:0]     active_ff, active_in;
   logic [CHANNELS-1:0]     restart_ff, restart_in;
   logic [CHANNELS-1:0]     handle_ff, handle_in;
   logic                    pend_valid_ff, pend_valid_in;
   result_type              pend_ff, pend_in;
   logic                    out_valid_ff, out_valid_in;
   result_type              out_ff, out_in;
   logic                    out_last_ff, out_last_in;

   time_type                stamp_mem [CHANNELS];
   time_type                limit_mem [CHANNELS];
   time_type                stamp_rd_ff;
   time_type                limit_rd_ff;

   logic                    stamp_we, limit_we;
   idx_type                 wr_addr;
   time_type                stamp_wd, limit_wd;

   logic                    accept, slot_ok, out_free, hit, last_idx;
   idx_type                 req_idx;
   time_type                req_now, elapsed;
   op_type                  req_op;

   assign req_op   = op_type'(req.op);
   assign accept   = req.valid && req.ready;
   assign req_idx  = idx_type'(req.slot);
   assign slot_ok  = ({28'd0, req.slot} < 32'(CHANNELS));
   assign req_now  = time_type'(req.now_ms);
   assign out_free = !out_valid_ff || rsp.ready;
   assign elapsed  = now_ff - stamp_rd_ff;
   assign hit      = active_ff[idx_ff] && (limit_rd_ff != '0) && (elapsed > limit_rd_ff);
   assign last_idx = (idx_ff == idx_type'(CHANNELS - 1));

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.hit_slot    = out_ff.hit_slot;
   assign rsp.action      = out_ff.action;
   assign rsp.kill_first  = out_ff.kill_first;
   assign rsp.last_of_run = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      active_in     = active_ff;
      restart_in    = restart_ff;
      handle_in     = handle_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      stamp_we      = 1'b0;
      limit_we      = 1'b0;
      wr_addr       = req_idx;
      stamp_wd      = req_now;
      limit_wd      = time_type'(req.limit_ms);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_REGISTER: begin
                     if (slot_ok) begin
                        stamp_we            = 1'b1;
                        limit_we            = 1'b1;
                        active_in[req_idx]  = 1'b1;
                        restart_in[req_idx] = req.can_restart;
                        handle_in[req_idx]  = req.holds_handle;
                     end
                  end
                  OP_HEARTBEAT: begin
                     stamp_we = slot_ok && active_ff[req_idx];
                  end
                  OP_CHECK: begin
                     now_in   = req_now;
                     idx_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!hit) begin
               if (last_idx) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else if (!pend_valid_ff || out_free) begin
               stamp_we = 1'b1;
               wr_addr  = idx_ff;
               stamp_wd = now_ff;
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_in       = pend_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in    = 1'b1;
               pend_in.hit_slot = 4'(idx_ff);
               cnt_in           = cnt_ff + 1'b1;
               if (restart_ff[idx_ff]) begin
                  pend_in.action     = ACT_RESTART;
                  pend_in.kill_first = handle_ff[idx_ff];
                  handle_in[idx_ff]  = 1'b0;
                  if (last_idx || (cnt_in == cnt_type'(MAX_RESULTS))) begin
                     state_in = ST_FLUSH;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end else begin
                  pend_in.action     = ACT_SYSRESET;
                  pend_in.kill_first = 1'b0;
                  state_in           = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      now_ff      <= now_in;
      restart_ff  <= restart_in;
      handle_ff   <= handle_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[wr_addr] <= stamp_wd;
      end
      if (limit_we) begin
         limit_mem[wr_addr] <= limit_wd;
      end
      stamp_rd_ff <= stamp_mem[idx_ff];
      limit_rd_ff <= limit_mem[idx_ff];
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over after check");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cnt_type'(MAX_RESULTS))
      else $error("result count overflow");

   a_sysreset_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.action == ACT_SYSRESET) |-> (rsp.last_of_run && !rsp.kill_first))
      else $error("system reset result not final or has kill");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |=> !req.ready || !pend_valid_ff)
      else $error("request taken with a result still held");

endmodule
